FILE: hdl/rc4lk_pkg.sv
// Shared types and constants for the length-keyed RC4 cipher core.
package rc4lk_pkg;

    localparam int unsigned TABLE_DEPTH   = 256;
    localparam int unsigned ADDR_W        = 8;
    localparam int unsigned MAX_KEY_BYTES = 32;
    localparam int unsigned KEY_WORDS     = 4;

    localparam logic [5:0] KEY_LENGTH_RESET = 6'd16;
    localparam logic [5:0] KEY_LENGTH_MAX   = 6'(MAX_KEY_BYTES);

    // Configuration register indexes.
    localparam logic [2:0] CFG_KEY_LENGTH = 3'd0;
    localparam logic [2:0] CFG_KEY_WORD_0 = 3'd1;
    localparam logic [2:0] CFG_KEY_WORD_1 = 3'd2;
    localparam logic [2:0] CFG_KEY_WORD_2 = 3'd3;
    localparam logic [2:0] CFG_KEY_WORD_3 = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_K_RW,
        ST_K_RJ,
        ST_K_WW,
        ST_K_WJ,
        ST_P_RI,
        ST_P_RJ,
        ST_P_WI,
        ST_P_WJ
    } state_t;

    // Request to the permutation memory for one cycle.
    typedef struct packed {
        logic              clear;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

FILE: hdl/rc4lk_perm_ram.sv
// Permutation table memory with write-first forwarding and identity valid bits.
module rc4lk_perm_ram (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rc4lk_pkg::ram_req_t    req,
    output logic [7:0]             rd_data
);

    logic [7:0]                         mem [rc4lk_pkg::TABLE_DEPTH];
    logic [rc4lk_pkg::TABLE_DEPTH-1:0]  valid_reg;
    logic [7:0]                         rd_mem_reg;
    logic [rc4lk_pkg::ADDR_W-1:0]       rd_addr_reg;
    logic                               rd_use_reg;
    logic                               same_addr;

    assign same_addr = req.we && (req.waddr == req.raddr);

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (same_addr) begin
            rd_mem_reg <= req.wdata;
        end else begin
            rd_mem_reg <= mem[req.raddr];
        end
        rd_use_reg  <= same_addr || valid_reg[req.raddr];
        rd_addr_reg <= req.raddr;
    end

    // An entry that has not been written since the last clear holds its own address.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.clear) begin
            valid_reg <= '0;
        end else if (req.we) begin
            valid_reg[req.waddr] <= 1'b1;
        end
    end

    assign rd_data = rd_use_reg ? rd_mem_reg : rd_addr_reg;

endmodule

FILE: hdl/rc4_length_keyed_stream_cipher_core.sv
// A byte's result loads in ST_P_WJ, after ST_P_RJ and ST_P_WI; a start byte first runs the
// key schedule (identity restore, 256 steps of ST_K_RJ, ST_K_WW, ST_K_WJ), then ST_P_RI.
// The read, read, swap sequence on the single-write-port permutation memory sets the rate;
// a new byte can be taken in ST_P_WJ if the output is free; the key schedule stalls input.
// Reset (aresetn low, synchronous): identity table, i = j = 0, key_length 16, keys zero,
// no result pending.
module rc4_length_keyed_stream_cipher_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_start_req,
    input  logic [7:0]  s_length_low,
    input  logic [7:0]  s_data_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_data_out
);

    rc4lk_pkg::state_t   state_reg, state_next;
    rc4lk_pkg::ram_req_t ram_req;
    logic [7:0]          rd_data;

    logic [5:0]  key_length_reg;
    logic [63:0] key_word_reg [rc4lk_pkg::KEY_WORDS];

    logic [7:0]  i_reg, j_reg, w_reg;
    logic [4:0]  k_reg;
    logic [7:0]  dep_reg, data_reg;
    logic [7:0]  sa_reg, sb_reg, t_reg;
    logic        m_valid_reg;
    logic [7:0]  m_data_reg;

    logic        in_xfer, out_free, out_load;
    logic [5:0]  klen_eff;
    logic [7:0]  key_byte;
    logic [7:0]  j_ksa;
    logic [7:0]  ks;
    logic        k_wrap;

    rc4lk_perm_ram u_perm_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg <= rc4lk_pkg::KEY_LENGTH_RESET;
            for (int n = 0; n < rc4lk_pkg::KEY_WORDS; n++) begin
                key_word_reg[n] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rc4lk_pkg::CFG_KEY_LENGTH: key_length_reg  <= cfg_wr_data[5:0];
                rc4lk_pkg::CFG_KEY_WORD_0: key_word_reg[0] <= cfg_wr_data;
                rc4lk_pkg::CFG_KEY_WORD_1: key_word_reg[1] <= cfg_wr_data;
                rc4lk_pkg::CFG_KEY_WORD_2: key_word_reg[2] <= cfg_wr_data;
                rc4lk_pkg::CFG_KEY_WORD_3: key_word_reg[3] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // A zero key length acts as one byte; longer than the key store saturates.
    always_comb begin
        if (key_length_reg == 6'd0) begin
            klen_eff = 6'd1;
        end else if (key_length_reg > rc4lk_pkg::KEY_LENGTH_MAX) begin
            klen_eff = rc4lk_pkg::KEY_LENGTH_MAX;
        end else begin
            klen_eff = key_length_reg;
        end
    end

    assign key_byte = key_word_reg[k_reg[4:3]][{k_reg[2:0], 3'b000} +: 8];
    assign k_wrap   = ({1'b0, k_reg} + 6'd1) >= klen_eff;
    assign j_ksa    = j_reg + rd_data + key_byte + dep_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign in_xfer  = s_valid && s_ready;

    // The read of S[s_i + s_j] returned the old S[j]; after the swap that entry holds s_i.
    always_comb begin
        if (t_reg == j_reg) begin
            ks = sa_reg;
        end else if (t_reg == i_reg) begin
            ks = sb_reg;
        end else begin
            ks = rd_data;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rc4lk_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    state_next = s_start_req ? rc4lk_pkg::ST_K_RW : rc4lk_pkg::ST_P_RJ;
                end
            end
            rc4lk_pkg::ST_K_RW: state_next = rc4lk_pkg::ST_K_RJ;
            rc4lk_pkg::ST_K_RJ: state_next = rc4lk_pkg::ST_K_WW;
            rc4lk_pkg::ST_K_WW: state_next = rc4lk_pkg::ST_K_WJ;
            rc4lk_pkg::ST_K_WJ: begin
                state_next = (w_reg == 8'hFF) ? rc4lk_pkg::ST_P_RI : rc4lk_pkg::ST_K_RJ;
            end
            rc4lk_pkg::ST_P_RI: state_next = rc4lk_pkg::ST_P_RJ;
            rc4lk_pkg::ST_P_RJ: state_next = rc4lk_pkg::ST_P_WI;
            rc4lk_pkg::ST_P_WI: state_next = rc4lk_pkg::ST_P_WJ;
            rc4lk_pkg::ST_P_WJ: begin
                if (out_free) begin
                    if (in_xfer) begin
                        state_next = s_start_req ? rc4lk_pkg::ST_K_RW : rc4lk_pkg::ST_P_RJ;
                    end else begin
                        state_next = rc4lk_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = rc4lk_pkg::ST_IDLE;
        endcase
    end

    // Memory requests, input ready and output load.
    always_comb begin
        ram_req       = '0;
        s_ready       = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            rc4lk_pkg::ST_IDLE: begin
                s_ready       = 1'b1;
                ram_req.raddr = i_reg + 8'd1;
            end
            rc4lk_pkg::ST_K_RW: begin
                ram_req.raddr = w_reg;
            end
            rc4lk_pkg::ST_K_RJ: begin
                ram_req.raddr = j_ksa;
            end
            rc4lk_pkg::ST_K_WW: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = w_reg;
                ram_req.wdata = rd_data;
            end
            rc4lk_pkg::ST_K_WJ: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = j_reg;
                ram_req.wdata = sa_reg;
                ram_req.raddr = w_reg + 8'd1;
            end
            rc4lk_pkg::ST_P_RI: begin
                ram_req.raddr = i_reg + 8'd1;
            end
            rc4lk_pkg::ST_P_RJ: begin
                ram_req.raddr = j_reg + rd_data;
            end
            rc4lk_pkg::ST_P_WI: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = i_reg;
                ram_req.wdata = rd_data;
                ram_req.raddr = sa_reg + rd_data;
            end
            rc4lk_pkg::ST_P_WJ: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = j_reg;
                ram_req.wdata = sa_reg;
                s_ready       = out_free;
                out_load      = out_free;
                // While the result waits, keep reading the keystream entry so it stays valid.
                ram_req.raddr = (out_free && s_valid && !s_start_req) ? (i_reg + 8'd1) : t_reg;
            end
            default: ;
        endcase
        ram_req.clear = in_xfer && s_start_req;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rc4lk_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Indexes and working registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg <= '0;
            j_reg <= '0;
        end else begin
            if (in_xfer) begin
                if (s_start_req) begin
                    j_reg <= '0;
                end else begin
                    i_reg <= i_reg + 8'd1;
                end
            end
            case (state_reg)
                rc4lk_pkg::ST_K_RJ: j_reg <= j_ksa;
                rc4lk_pkg::ST_K_WJ: begin
                    if (w_reg == 8'hFF) begin
                        i_reg <= '0;
                        j_reg <= '0;
                    end
                end
                rc4lk_pkg::ST_P_RI: i_reg <= i_reg + 8'd1;
                rc4lk_pkg::ST_P_RJ: j_reg <= j_reg + rd_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            data_reg <= s_data_in;
            if (s_start_req) begin
                dep_reg <= {s_length_low[6:0], 1'b0};
                w_reg   <= '0;
                k_reg   <= '0;
            end
        end
        case (state_reg)
            rc4lk_pkg::ST_K_RJ: sa_reg <= rd_data;
            rc4lk_pkg::ST_K_WJ: begin
                w_reg <= w_reg + 8'd1;
                k_reg <= k_wrap ? 5'd0 : (k_reg + 5'd1);
            end
            rc4lk_pkg::ST_P_RJ: sa_reg <= rd_data;
            rc4lk_pkg::ST_P_WI: begin
                sb_reg <= rd_data;
                t_reg  <= sa_reg + rd_data;
            end
            default: ;
        endcase
    end

    // Output register: holds one result until its transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= data_reg ^ ks;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_data_out = m_data_reg;

endmodule

FILE: test/tb_rc4_length_keyed_stream_cipher_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the length-keyed RC4 stream cipher core.
module tb_rc4_length_keyed_stream_cipher_core;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 6;
    localparam int STALL_LIMIT  = 6000;
    localparam int TAIL_CYCLES  = 16;
    localparam int REPORT_LIMIT = 10;
    localparam int RANDOM_PHASES   = 5;
    localparam int BYTES_PER_PHASE = 250;

    typedef struct packed {
        logic       start_req;
        logic [7:0] length_low;
        logic [7:0] data_in;
    } cipher_in_t;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [2:0]  cfg_index    = rc4lk_pkg::CFG_KEY_LENGTH;
    logic [63:0] cfg_wr_data  = '0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic        s_start_req  = 1'b0;
    logic [7:0]  s_length_low = '0;
    logic [7:0]  s_data_in    = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [7:0]  m_data_out;

    // Predictor state: permutation, generator indexes and the key registers.
    logic [7:0]  perm [0:rc4lk_pkg::TABLE_DEPTH-1];
    logic [7:0]  gen_i;
    logic [7:0]  gen_j;
    logic [5:0]  key_len_reg;
    logic [63:0] key_reg [0:rc4lk_pkg::KEY_WORDS-1];

    cipher_in_t  byte_queue[$];
    logic [7:0]  expected_bytes[$];
    int          bytes_pushed = 0;
    int          results_done = 0;
    int          mismatches   = 0;
    int          stall_cycles = 0;
    int          send_gap     = 0;
    int          recv_gap     = 0;
    bit          s_accepted   = 1'b0;
    bit          bursts_on    = 1'b1;

    rc4_length_keyed_stream_cipher_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_start_req (s_start_req),
        .s_length_low(s_length_low),
        .s_data_in   (s_data_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_out  (m_data_out)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Advances the cipher by one byte, rekeying first when the byte opens a message.
    function automatic logic [7:0] encipher_byte(input logic start, input logic [7:0] len_low,
                                                 input logic [7:0] din);
        int unsigned klen;
        int unsigned k;
        logic [7:0]  mix;
        logic [7:0]  jj;
        logic [7:0]  tmp;
        if (start) begin
            klen = key_len_reg;
            if (klen == 0) klen = 1;
            if (klen > rc4lk_pkg::MAX_KEY_BYTES) klen = rc4lk_pkg::MAX_KEY_BYTES;
            mix = {len_low[6:0], 1'b0};
            jj  = '0;
            k   = 0;
            for (int w = 0; w < rc4lk_pkg::TABLE_DEPTH; w++) perm[w] = w[7:0];
            for (int w = 0; w < rc4lk_pkg::TABLE_DEPTH; w++) begin
                jj = jj + perm[w] + key_reg[k / 8][(k % 8) * 8 +: 8] + mix;
                tmp = perm[w];
                perm[w] = perm[jj];
                perm[jj] = tmp;
                k = (k + 1 >= klen) ? 0 : k + 1;
            end
            gen_i = '0;
            gen_j = '0;
        end
        gen_i = gen_i + 8'd1;
        gen_j = gen_j + perm[gen_i];
        tmp = perm[gen_i];
        perm[gen_i] = perm[gen_j];
        perm[gen_j] = tmp;
        return din ^ perm[8'(perm[gen_i] + perm[gen_j])];
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            rc4lk_pkg::CFG_KEY_LENGTH: key_len_reg = value[5:0];
            rc4lk_pkg::CFG_KEY_WORD_0: key_reg[0] = value;
            rc4lk_pkg::CFG_KEY_WORD_1: key_reg[1] = value;
            rc4lk_pkg::CFG_KEY_WORD_2: key_reg[2] = value;
            rc4lk_pkg::CFG_KEY_WORD_3: key_reg[3] = value;
            default: ;
        endcase
    endtask

    task automatic load_key(input logic [5:0] len);
        write_reg(rc4lk_pkg::CFG_KEY_LENGTH, 64'(len));
        write_reg(rc4lk_pkg::CFG_KEY_WORD_0, {$urandom, $urandom});
        write_reg(rc4lk_pkg::CFG_KEY_WORD_1, {$urandom, $urandom});
        write_reg(rc4lk_pkg::CFG_KEY_WORD_2, {$urandom, $urandom});
        write_reg(rc4lk_pkg::CFG_KEY_WORD_3, {$urandom, $urandom});
    endtask

    task automatic push_byte(input logic start, input logic [7:0] len_low,
                             input logic [7:0] din);
        byte_queue.push_back('{start, len_low, din});
        bytes_pushed++;
    endtask

    // Holds the test sequence off until every queued byte has come back.
    task automatic wait_drained;
        while (results_done != bytes_pushed) @(negedge aclk);
    endtask

    // Sender: presents queued bytes, with random gaps between transfers while bursts are on.
    always @(negedge aclk) begin : sender
        cipher_in_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_accepted) begin
            if (s_accepted && bursts_on && $urandom_range(0, 3) == 0)
                send_gap = $urandom_range(1, 8);
            s_accepted = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (byte_queue.size() != 0) begin
                nxt = byte_queue.pop_front();
                s_valid      <= 1'b1;
                s_start_req  <= nxt.start_req;
                s_length_low <= nxt.length_low;
                s_data_in    <= nxt.data_in;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: accepts results, stalling in random bursts while bursts are on.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (bursts_on && $urandom_range(0, 4) == 0) recv_gap = $urandom_range(1, 8);
        end
    end

    always @(posedge aclk) begin : monitor
        logic [7:0] want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_bytes.push_back(encipher_byte(s_start_req, s_length_low, s_data_in));
                s_accepted = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("Unexpected result transfer: data_out %02h at %0t",
                                 m_data_out, $time);
                end else begin
                    want = expected_bytes.pop_front();
                    results_done++;
                    if (m_data_out !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("data_out mismatch on byte %0d: expected %02h, got %02h",
                                     results_done, want, m_data_out);
                    end
                end
            end
        end
    end

    // Ends the run if no transfer of any kind happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int msg_len;
        int sent;
        logic [5:0] klen;

        for (int w = 0; w < rc4lk_pkg::TABLE_DEPTH; w++) perm[w] = w[7:0];
        gen_i = '0;
        gen_j = '0;
        key_len_reg = rc4lk_pkg::KEY_LENGTH_RESET;
        for (int w = 0; w < rc4lk_pkg::KEY_WORDS; w++) key_reg[w] = '0;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Bytes without a start run on from the reset permutation.
        push_byte(1'b0, 8'hFF, 8'h00);
        push_byte(1'b0, 8'h00, 8'hFF);
        push_byte(1'b0, 8'h5A, 8'hA5);
        // Default key, shortest and longest length bytes; the doubling drops bit 7.
        push_byte(1'b1, 8'h00, 8'h00);
        push_byte(1'b0, 8'h00, 8'hFF);
        push_byte(1'b1, 8'hFF, 8'hFF);
        push_byte(1'b0, 8'hFF, 8'h00);
        push_byte(1'b1, 8'h80, 8'h3C);
        wait_drained();

        // One-byte key of all ones.
        write_reg(rc4lk_pkg::CFG_KEY_LENGTH, 64'd1);
        write_reg(rc4lk_pkg::CFG_KEY_WORD_0, '1);
        write_reg(rc4lk_pkg::CFG_KEY_WORD_1, '1);
        write_reg(rc4lk_pkg::CFG_KEY_WORD_2, '1);
        write_reg(rc4lk_pkg::CFG_KEY_WORD_3, '1);
        push_byte(1'b1, 8'h01, 8'h00);
        push_byte(1'b0, 8'h7F, 8'hC3);
        wait_drained();

        // Full-length key; writes to unused indexes must leave it alone.
        load_key(rc4lk_pkg::KEY_LENGTH_MAX);
        for (int r = rc4lk_pkg::CFG_KEY_WORD_3 + 1; r < 2 ** $bits(cfg_index); r++)
            write_reg(3'(r), '1);
        push_byte(1'b1, 8'h2A, 8'h81);
        push_byte(1'b0, 8'h00, 8'h7E);
        push_byte(1'b0, 8'h00, 8'h00);
        wait_drained();

        // A zero key length acts as one byte.
        write_reg(rc4lk_pkg::CFG_KEY_LENGTH, 64'd0);
        push_byte(1'b1, 8'h10, 8'h55);
        push_byte(1'b0, 8'h10, 8'hAA);
        wait_drained();

        // Key lengths above the maximum saturate.
        write_reg(rc4lk_pkg::CFG_KEY_LENGTH, 64'h3F);
        push_byte(1'b1, 8'hC4, 8'h0F);
        push_byte(1'b0, 8'hC4, 8'hF0);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: klen = 6'd1;
                1: klen = rc4lk_pkg::KEY_LENGTH_MAX;
                default: klen = 6'($urandom_range(0, 63));
            endcase
            load_key(klen);
            // The closing phase runs with both sides always ready.
            bursts_on = (p != RANDOM_PHASES - 1);
            sent = 0;
            while (sent < BYTES_PER_PHASE) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_byte(1'b0, 8'($urandom), 8'($urandom));
                    sent++;
                end else begin
                    msg_len = $urandom_range(1, 32);
                    if (msg_len > BYTES_PER_PHASE - sent) msg_len = BYTES_PER_PHASE - sent;
                    push_byte(1'b1, $urandom_range(0, 1) ? 8'(msg_len) : 8'($urandom),
                              8'($urandom));
                    for (int b = 1; b < msg_len; b++)
                        push_byte(1'b0, 8'($urandom), 8'($urandom));
                    sent += msg_len;
                end
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
